[rtl/qadd_pkg.sv]
// Shared types, widths and codes for the quantized int8 add pipeline.
`timescale 1ns / 1ps

package qadd_pkg;

  // Fraction bits of the Q8.24 multipliers.
  localparam int MULT_FRAC_BITS = 24;

  localparam int SAMPLE_W = 8;
  localparam int MULT_W   = 32;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int PROD_W   = DIFF_W + MULT_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int FLOOR_W  = SUM_W - MULT_FRAC_BITS;
  localparam int RND_W    = FLOOR_W + 1;
  localparam int ACC_W    = RND_W + 1;
  localparam int CFG_IDX_W = 3;

  localparam logic [MULT_W-1:0] MULT_RESET = MULT_W'(1) << MULT_FRAC_BITS;
  localparam logic [MULT_FRAC_BITS-1:0] ROUND_HALF =
    {1'b1, {(MULT_FRAC_BITS-1){1'b0}}};

  // Broadcast mode codes; the fourth code acts as no broadcast.
  localparam logic [1:0] BC_HOLD_A = 2'd0;
  localparam logic [1:0] BC_HOLD_B = 2'd1;
  localparam logic [1:0] BC_NONE   = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZP_A       = 3'd0,
    REG_ZP_B       = 3'd1,
    REG_ZP_OUT     = 3'd2,
    REG_MULT_A     = 3'd3,
    REG_MULT_B     = 3'd4,
    REG_CLAMP_LOW  = 3'd5,
    REG_CLAMP_HIGH = 3'd6,
    REG_BCAST_MODE = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] zp_a;
    logic signed [SAMPLE_W-1:0] zp_b;
    logic signed [SAMPLE_W-1:0] zp_out;
    logic        [MULT_W-1:0]   mult_a;
    logic        [MULT_W-1:0]   mult_b;
    logic signed [SAMPLE_W-1:0] clamp_low;
    logic signed [SAMPLE_W-1:0] clamp_high;
    logic        [1:0]          bcast_mode;
  } qadd_cfg_t;

endpackage

[rtl/quantized_int8_add_top.sv]
// Top level of the quantized int8 elementwise add pipeline.
`timescale 1ns / 1ps

// Quantized int8 elementwise add. Each input beat carries one pair of int8
// samples; the block removes each operand's zero point, scales each
// difference by its own unsigned Q8.24 multiplier, adds the exact products,
// rounds to nearest with ties to even, adds the output zero point and clamps
// the result to [clamp_low, clamp_high]. In broadcast mode one operand is
// replaced by the raw sample latched on the beat flagged first_of_run. The
// block takes one beat per clock cycle while in_stall is low and delivers
// one result beat per input beat, in order. The four register stages are
// operand select and zero point removal, the two parallel 9x33 bit
// multiplies, the 42 bit product sum, and the rounding, zero point and clamp
// stage that drives the output register. Each stage advances whenever it is
// empty or the stage after it moves, so bubbles are squeezed out and the
// input keeps accepting while a finished result waits on out_stall until
// all four stages are full.
// Configuration registers are written through the cfg_ port, which is always
// ready; write them only while no beat is in flight.

module quantized_int8_add_top import qadd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_a,
  input  logic signed [SAMPLE_W-1:0] in_sample_b,
  input  logic                       in_first_of_run,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sum_out,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [MULT_W-1:0]          cfg_data
);

  qadd_cfg_t                cfg;
  logic                     diff_vld;
  logic signed [DIFF_W-1:0] diff_a;
  logic signed [DIFF_W-1:0] diff_b;
  logic                     prod_vld;
  logic                     sum_vld;
  logic signed [SUM_W-1:0]  sum;

  // Stage enables: a stage loads when it is empty or its successor loads.
  logic en_op;
  logic en_prod;
  logic en_sum;
  logic en_out;

  assign en_out   = !out_valid || !out_stall;
  assign en_sum   = !sum_vld || en_out;
  assign en_prod  = !prod_vld || en_sum;
  assign en_op    = !diff_vld || en_prod;
  assign in_stall = !en_op;

  qadd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  qadd_operand u_operand (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (in_valid),
    .stage_en     (en_op),
    .sample_a     (in_sample_a),
    .sample_b     (in_sample_b),
    .first_of_run (in_first_of_run),
    .cfg          (cfg),
    .vld          (diff_vld),
    .diff_a       (diff_a),
    .diff_b       (diff_b)
  );

  qadd_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .diff_vld (diff_vld),
    .diff_a   (diff_a),
    .diff_b   (diff_b),
    .prod_en  (en_prod),
    .sum_en   (en_sum),
    .cfg      (cfg),
    .prod_vld (prod_vld),
    .sum_vld  (sum_vld),
    .sum      (sum)
  );

  qadd_requant u_requant (
    .clk     (clk),
    .rst_n   (rst_n),
    .sum_vld (sum_vld),
    .sum     (sum),
    .out_en  (en_out),
    .cfg     (cfg),
    .vld     (out_valid),
    .result  (out_sum_out)
  );

  // The input is held off only when every stage holds a beat and the
  // output beat is blocked.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (diff_vld && prod_vld && sum_vld && out_valid && out_stall))
    else $error("input stalled while the pipeline had room");

  // A beat in the sum stage with a free output reaches the output next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (sum_vld && en_out) |=> out_valid)
    else $error("sum stage beat did not reach the output register");

endmodule

[rtl/qadd_cfg_regs.sv]
// Configuration register file of the quantized int8 add block.
`timescale 1ns / 1ps

module qadd_cfg_regs import qadd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MULT_W-1:0]    cfg_data,
  output qadd_cfg_t            cfg
);

  qadd_cfg_t cfg_r;
  qadd_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_ZP_A:       cfg_nxt.zp_a       = cfg_data[SAMPLE_W-1:0];
        REG_ZP_B:       cfg_nxt.zp_b       = cfg_data[SAMPLE_W-1:0];
        REG_ZP_OUT:     cfg_nxt.zp_out     = cfg_data[SAMPLE_W-1:0];
        REG_MULT_A:     cfg_nxt.mult_a     = cfg_data;
        REG_MULT_B:     cfg_nxt.mult_b     = cfg_data;
        REG_CLAMP_LOW:  cfg_nxt.clamp_low  = cfg_data[SAMPLE_W-1:0];
        REG_CLAMP_HIGH: cfg_nxt.clamp_high = cfg_data[SAMPLE_W-1:0];
        REG_BCAST_MODE: cfg_nxt.bcast_mode = cfg_data[1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zp_a       <= '0;
      cfg_r.zp_b       <= '0;
      cfg_r.zp_out     <= '0;
      cfg_r.mult_a     <= MULT_RESET;
      cfg_r.mult_b     <= MULT_RESET;
      cfg_r.clamp_low  <= {1'b1, {(SAMPLE_W-1){1'b0}}};
      cfg_r.clamp_high <= {1'b0, {(SAMPLE_W-1){1'b1}}};
      cfg_r.bcast_mode <= BC_NONE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/qadd_operand.sv]
// First pipeline stage: broadcast operand selection and zero point removal.
`timescale 1ns / 1ps

module qadd_operand import qadd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic                       stage_en,
  input  logic signed [SAMPLE_W-1:0] sample_a,
  input  logic signed [SAMPLE_W-1:0] sample_b,
  input  logic                       first_of_run,
  input  qadd_cfg_t                  cfg,
  output logic                       vld,
  output logic signed [DIFF_W-1:0]   diff_a,
  output logic signed [DIFF_W-1:0]   diff_b
);

  logic                       vld_r;
  logic signed [SAMPLE_W-1:0] held_r;
  logic signed [SAMPLE_W-1:0] held_nxt;
  logic signed [DIFF_W-1:0]   diff_a_r;
  logic signed [DIFF_W-1:0]   diff_b_r;
  logic signed [DIFF_W-1:0]   diff_a_nxt;
  logic signed [DIFF_W-1:0]   diff_b_nxt;
  logic signed [SAMPLE_W-1:0] sel_a;
  logic signed [SAMPLE_W-1:0] sel_b;
  logic                       accept;

  assign accept = in_vld && stage_en;

  always_comb begin
    held_nxt = held_r;
    sel_a    = sample_a;
    sel_b    = sample_b;
    if (cfg.bcast_mode == BC_HOLD_A) begin
      if (first_of_run) begin
        held_nxt = sample_a;
      end
      sel_a = first_of_run ? sample_a : held_r;
    end else if (cfg.bcast_mode == BC_HOLD_B) begin
      if (first_of_run) begin
        held_nxt = sample_b;
      end
      sel_b = first_of_run ? sample_b : held_r;
    end
    diff_a_nxt = DIFF_W'(sel_a) - DIFF_W'(cfg.zp_a);
    diff_b_nxt = DIFF_W'(sel_b) - DIFF_W'(cfg.zp_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      held_r <= '0;
    end else begin
      if (stage_en) begin
        vld_r <= in_vld;
      end
      if (accept) begin
        held_r <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      diff_a_r <= diff_a_nxt;
      diff_b_r <= diff_b_nxt;
    end
  end

  assign vld    = vld_r;
  assign diff_a = diff_a_r;
  assign diff_b = diff_b_r;

  // A run start in hold-a mode latches the raw a sample of that beat.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && first_of_run && cfg.bcast_mode == BC_HOLD_A)
      |=> (held_r == $past(sample_a)))
    else $error("held operand did not latch sample a");

endmodule

[rtl/qadd_scale.sv]
// Multiply and sum stages: scales both differences and adds the exact products.
`timescale 1ns / 1ps

module qadd_scale import qadd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     diff_vld,
  input  logic signed [DIFF_W-1:0] diff_a,
  input  logic signed [DIFF_W-1:0] diff_b,
  input  logic                     prod_en,
  input  logic                     sum_en,
  input  qadd_cfg_t                cfg,
  output logic                     prod_vld,
  output logic                     sum_vld,
  output logic signed [SUM_W-1:0]  sum
);

  logic                     prod_vld_r;
  logic                     sum_vld_r;
  logic signed [PROD_W-1:0] prod_a_r;
  logic signed [PROD_W-1:0] prod_b_r;
  logic signed [PROD_W-1:0] prod_a_nxt;
  logic signed [PROD_W-1:0] prod_b_nxt;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;

  // Signed 9-bit difference times unsigned 32-bit multiplier.
  always_comb begin
    prod_a_nxt = PROD_W'(diff_a) * PROD_W'($signed({1'b0, cfg.mult_a}));
    prod_b_nxt = PROD_W'(diff_b) * PROD_W'($signed({1'b0, cfg.mult_b}));
    sum_nxt    = SUM_W'(prod_a_r) + SUM_W'(prod_b_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      sum_vld_r  <= 1'b0;
    end else begin
      if (prod_en) begin
        prod_vld_r <= diff_vld;
      end
      if (sum_en) begin
        sum_vld_r <= prod_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod_a_r <= prod_a_nxt;
      prod_b_r <= prod_b_nxt;
    end
    if (sum_en) begin
      sum_r <= sum_nxt;
    end
  end

  assign prod_vld = prod_vld_r;
  assign sum_vld  = sum_vld_r;
  assign sum      = sum_r;

  // A held product stage keeps its beat until the sum stage takes it.
  assert property (@(posedge clk) disable iff (!rst_n)
    (prod_vld_r && !sum_en) |=> (prod_vld_r && $stable(prod_a_r) && $stable(prod_b_r)))
    else $error("product stage lost a beat while the sum stage was blocked");

endmodule

[rtl/qadd_requant.sv]
// Output stage: round half to even, add the output zero point and clamp.
`timescale 1ns / 1ps

module qadd_requant import qadd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       sum_vld,
  input  logic signed [SUM_W-1:0]    sum,
  input  logic                       out_en,
  input  qadd_cfg_t                  cfg,
  output logic                       vld,
  output logic signed [SAMPLE_W-1:0] result
);

  logic                          vld_r;
  logic signed [SAMPLE_W-1:0]    result_r;
  logic signed [SAMPLE_W-1:0]    result_nxt;
  logic signed [FLOOR_W-1:0]     floor_v;
  logic [MULT_FRAC_BITS-1:0]     rem;
  logic                          round_up;
  logic signed [RND_W-1:0]       rnd;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       lo_ext;
  logic signed [ACC_W-1:0]       hi_ext;
  logic signed [ACC_W-1:0]       clamped;

  always_comb begin
    floor_v  = sum[SUM_W-1:MULT_FRAC_BITS];
    rem      = sum[MULT_FRAC_BITS-1:0];
    round_up = (rem > ROUND_HALF) || ((rem == ROUND_HALF) && floor_v[0]);
    rnd      = RND_W'(floor_v) + $signed({{(RND_W-1){1'b0}}, round_up});
    acc      = ACC_W'(rnd) + ACC_W'(cfg.zp_out);
    lo_ext   = ACC_W'(cfg.clamp_low);
    hi_ext   = ACC_W'(cfg.clamp_high);
    // Low bound first, then high bound, so crossed bounds give the high one.
    clamped  = acc;
    if (clamped < lo_ext) begin
      clamped = lo_ext;
    end
    if (clamped > hi_ext) begin
      clamped = hi_ext;
    end
    result_nxt = clamped[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (out_en) begin
      vld_r <= sum_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      result_r <= result_nxt;
    end
  end

  assign vld    = vld_r;
  assign result = result_r;

endmodule

[tb/sv/qadd_sum_checker.sv]
// Checker for the quantized int8 add: predicts every sum and compares it with the output.
`timescale 1ns / 1ps

module qadd_sum_checker import qadd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_a,
  input  logic signed [SAMPLE_W-1:0] in_sample_b,
  input  logic                       in_first_of_run,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] out_sum_out,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [MULT_W-1:0]          cfg_data,
  output int                         fail_count,
  output int                         outstanding,
  output int                         checked_count
);

  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    logic                       first;
    logic signed [SAMPLE_W-1:0] sum;
  } pending_sum_t;

  qadd_cfg_t            regs;
  logic [SAMPLE_W-1:0]  held_sample;
  pending_sum_t         pending_sums[$];
  pending_sum_t         entry;
  pending_sum_t         oldest;
  logic signed [SAMPLE_W-1:0] op_a;
  logic signed [SAMPLE_W-1:0] op_b;
  int                   fails;
  int                   checked;

  // Exact products, round half to even at the binary point, then offset and clamp.
  function automatic logic signed [SAMPLE_W-1:0] requantized_sum(
    input qadd_cfg_t r, input logic signed [SAMPLE_W-1:0] a, b);
    longint diff_a;
    longint diff_b;
    longint total;
    longint whole;
    logic [MULT_FRAC_BITS-1:0] frac;
    diff_a = longint'($signed(a)) - longint'($signed(r.zp_a));
    diff_b = longint'($signed(b)) - longint'($signed(r.zp_b));
    total  = diff_a * longint'({32'd0, r.mult_a}) + diff_b * longint'({32'd0, r.mult_b});
    whole  = total >>> MULT_FRAC_BITS;
    frac   = total[MULT_FRAC_BITS-1:0];
    if (frac > ROUND_HALF || (frac == ROUND_HALF && whole[0])) begin
      whole = whole + 1;
    end
    whole = whole + longint'($signed(r.zp_out));
    // Low bound first, then high, so crossed bounds give clamp_high.
    if (whole < longint'($signed(r.clamp_low))) begin
      whole = longint'($signed(r.clamp_low));
    end
    if (whole > longint'($signed(r.clamp_high))) begin
      whole = longint'($signed(r.clamp_high));
    end
    return whole[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.zp_a       = '0;
      regs.zp_b       = '0;
      regs.zp_out     = '0;
      regs.mult_a     = MULT_RESET;
      regs.mult_b     = MULT_RESET;
      regs.clamp_low  = 8'sh80;
      regs.clamp_high = 8'sh7F;
      regs.bcast_mode = BC_NONE;
      held_sample     = '0;
      pending_sums.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_ZP_A:       regs.zp_a       = cfg_data[SAMPLE_W-1:0];
          REG_ZP_B:       regs.zp_b       = cfg_data[SAMPLE_W-1:0];
          REG_ZP_OUT:     regs.zp_out     = cfg_data[SAMPLE_W-1:0];
          REG_MULT_A:     regs.mult_a     = cfg_data;
          REG_MULT_B:     regs.mult_b     = cfg_data;
          REG_CLAMP_LOW:  regs.clamp_low  = cfg_data[SAMPLE_W-1:0];
          REG_CLAMP_HIGH: regs.clamp_high = cfg_data[SAMPLE_W-1:0];
          REG_BCAST_MODE: regs.bcast_mode = cfg_data[1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (pending_sums.size() == 0) begin
          fails = fails + 1;
          if (fails <= REPORT_LIMIT) begin
            $display("[%0t] unexpected result beat: sum %0d", $realtime, out_sum_out);
          end
        end else begin
          oldest  = pending_sums.pop_front();
          checked = checked + 1;
          if (out_sum_out !== oldest.sum) begin
            fails = fails + 1;
            if (fails <= REPORT_LIMIT) begin
              $display("[%0t] sum mismatch for a=%0d b=%0d first=%0b: expected %0d, got %0d",
                       $realtime, oldest.a, oldest.b, oldest.first, oldest.sum, out_sum_out);
            end
          end
        end
      end

      if (in_valid && !in_stall) begin
        op_a = in_sample_a;
        op_b = in_sample_b;
        // The raw sample is held; the zero point in force now is applied to it.
        if (regs.bcast_mode == BC_HOLD_A) begin
          if (in_first_of_run) held_sample = in_sample_a;
          op_a = held_sample;
        end else if (regs.bcast_mode == BC_HOLD_B) begin
          if (in_first_of_run) held_sample = in_sample_b;
          op_b = held_sample;
        end
        entry.a     = in_sample_a;
        entry.b     = in_sample_b;
        entry.first = in_first_of_run;
        entry.sum   = requantized_sum(regs, op_a, op_b);
        pending_sums.push_back(entry);
      end
    end
    fail_count    <= fails;
    outstanding   <= pending_sums.size();
    checked_count <= checked;
  end

endmodule

[tb/sv/testbench.sv]
// Testbench top for the quantized int8 add: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

// The top drives three channels of the block and leaves all prediction and
// comparison to qadd_sum_checker, which watches the same wires and returns a
// failure count and the number of sums still owed by the block.
//
// The run has two parts. A short directed part covers the sample extremes
// under the reset settings, broadcast of operand a before any run has been
// latched, latching on the first beat of a run for both operands, the unused
// broadcast code, ties that must round to even (positive and negative), the
// largest zero points and multipliers, and clamp bounds that cross. The
// random part then goes through a series of register settings; within each,
// most beats form runs that start with first_of_run set, and a few carry a
// random flag instead so that stray run starts are exercised too.
module testbench import qadd_pkg::*;;

  localparam int          CLK_HALF_NS     = 6;
  localparam int          RESET_CYCLES    = 5;
  localparam int          LIMIT_CYCLES    = 400000;
  localparam int          RANDOM_PHASES   = 10;
  localparam int          PAIRS_PER_PHASE = 115;
  localparam int          PRESSURE_PHASE  = 3;
  localparam int          PRESSURE_PAIRS  = 24;
  localparam int          LONG_HOLD       = 64;
  localparam int          DRAIN_TAIL      = 8;
  // The fourth broadcast code is unused by the block and must act as no broadcast.
  localparam logic [1:0]  BC_UNUSED       = 2'd3;

  logic                       clk             = 1'b0;
  logic                       rst_n           = 1'b0;
  logic                       in_valid        = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_a     = '0;
  logic signed [SAMPLE_W-1:0] in_sample_b     = '0;
  logic                       in_first_of_run = 1'b0;
  logic                       out_valid;
  logic                       out_stall       = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sum_out;
  logic                       cfg_valid       = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index       = REG_ZP_A;
  logic [MULT_W-1:0]          cfg_data        = '0;

  int fail_count;
  int outstanding;
  int checked_count;

  int cycle_count      = 0;
  int pairs_sent       = 0;
  int directed_pairs   = 0;
  int broadcast_pairs  = 0;
  int settings_applied = 0;
  bit no_sender_gaps   = 1'b0;

  // Handshake between the stimulus and the result sink for the long hold-off.
  bit hold_off_req = 1'b0;
  bit hold_served  = 1'b0;
  bit hold_active  = 1'b0;

  quantized_int8_add_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_a     (in_sample_a),
    .in_sample_b     (in_sample_b),
    .in_first_of_run (in_first_of_run),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sum_out     (out_sum_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  qadd_sum_checker checker_inst (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_a     (in_sample_a),
    .in_sample_b     (in_sample_b),
    .in_first_of_run (in_first_of_run),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sum_out     (out_sum_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .checked_count   (checked_count)
  );

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  // Reset is held once at the start and never again.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
  end

  // The limit is several times the slowest legal run, so reaching it means a hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result sink. Each pass picks one stretch: free flow, a short or long stall,
  // or a short accepting burst. A pending hold-off request wins over all of them
  // and keeps out_stall high long enough for the four stages to fill and the
  // input to back up.
  initial begin : result_sink
    int pick;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req && !hold_served) begin
        hold_served  = 1'b1;
        hold_active  = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active  = 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(20, 80)) @(posedge clk);
        end else if (pick < 20) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(12, 40)) @(posedge clk);
        end else if (pick < 60) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
    end
  end

  // Idle cycles after a beat: mostly none or a few, rarely a long pause.
  function automatic int sender_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (no_sender_gaps || pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Samples lean toward the extremes and the values next to zero.
  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 11))
      0:       return 8'h80;
      1:       return 8'h7F;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return SAMPLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Realistic scale factors most of the time, with zero, one and the full range mixed in.
  function automatic logic [MULT_W-1:0] random_mult();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2:       return MULT_RESET;
      3:       return $urandom();
      default: return $urandom_range(32'h0010_0000, 32'h0200_0000);
    endcase
  endfunction

  // Offers one beat and returns at the edge that accepts it.
  task automatic offer_pair(input logic signed [SAMPLE_W-1:0] a, b, input logic first);
    in_valid        <= 1'b1;
    in_sample_a     <= a;
    in_sample_b     <= b;
    in_first_of_run <= first;
    do @(posedge clk); while (in_stall);
    pairs_sent = pairs_sent + 1;
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic feed(input logic signed [SAMPLE_W-1:0] a, b, input logic first);
    offer_pair(a, b, first);
    pause_sender(sender_gap());
  endtask

  // The extra edge lets the checker count the beat accepted at this same edge.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [MULT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Byte registers are written sign-extended so the upper data bits toggle too.
  task automatic apply_settings(input logic [SAMPLE_W-1:0] zpa, zpb, zpo,
                                input logic [MULT_W-1:0] ma, mb,
                                input logic [SAMPLE_W-1:0] lo, hi,
                                input logic [1:0] mode);
    write_reg(REG_ZP_A,       {{24{zpa[7]}}, zpa});
    write_reg(REG_ZP_B,       {{24{zpb[7]}}, zpb});
    write_reg(REG_ZP_OUT,     {{24{zpo[7]}}, zpo});
    write_reg(REG_MULT_A,     ma);
    write_reg(REG_MULT_B,     mb);
    write_reg(REG_CLAMP_LOW,  {{24{lo[7]}}, lo});
    write_reg(REG_CLAMP_HIGH, {{24{hi[7]}}, hi});
    write_reg(REG_BCAST_MODE, {30'd0, mode});
    settings_applied = settings_applied + 1;
  endtask

  // One random phase: fresh settings, then runs of beats with random content.
  // The pressure phase opens with a gapless burst while the sink holds off.
  task automatic run_random_phase(input int phase);
    int         run_left;
    int         lo;
    int         hi;
    int         pick;
    logic       first;
    logic [1:0] mode;
    run_left = 0;
    mode     = 2'($urandom_range(0, 3));
    pick     = $urandom_range(0, 9);
    if (pick == 0) begin
      // Crossed bounds: low above high.
      lo = $urandom_range(0, 127);
      hi = int'($urandom_range(0, lo + 127)) - 128;
    end else if (pick < 4) begin
      lo = -128;
      hi = 127;
    end else begin
      lo = int'($urandom_range(0, 128)) - 128;
      hi = $urandom_range(0, 127);
    end
    apply_settings(random_sample(), random_sample(), random_sample(),
                   random_mult(), random_mult(), SAMPLE_W'(lo), SAMPLE_W'(hi), mode);
    no_sender_gaps = (phase % 4 == 1);
    if (phase == PRESSURE_PHASE) begin
      hold_off_req = 1'b1;
      wait (hold_active);
    end
    for (int i = 0; i < PAIRS_PER_PHASE; i++) begin
      if (run_left == 0) begin
        first    = 1'b1;
        run_left = $urandom_range(1, 24);
      end else begin
        first = 1'b0;
      end
      run_left = run_left - 1;
      if ($urandom_range(0, 9) == 0) first = 1'($urandom_range(0, 1));
      offer_pair(random_sample(), random_sample(), first);
      if (mode == BC_HOLD_A || mode == BC_HOLD_B) broadcast_pairs = broadcast_pairs + 1;
      if (!(phase == PRESSURE_PHASE && i < PRESSURE_PAIRS)) pause_sender(sender_gap());
    end
    // The sender waits here until the block has delivered every sum it owes.
    wait_for_results();
    no_sender_gaps = 1'b0;
  endtask

  initial begin : stimulus
    wait (rst_n === 1'b1);
    @(posedge clk);

    // Reset settings: saturation both ways, and a run flag that must not latch
    // anything because broadcast is off.
    feed(127, 127, 1'b0);
    feed(-128, -128, 1'b0);
    feed(127, -128, 1'b1);
    feed(0, -1, 1'b0);
    wait_for_results();

    // Hold a before any run has started: the held operand is still zero.
    apply_settings(0, 0, 0, MULT_RESET, MULT_RESET, -128, 127, BC_HOLD_A);
    feed(50, 7, 1'b0);
    feed(-128, -1, 1'b1);
    feed(100, 3, 1'b0);
    wait_for_results();

    // Hold b: the value latched from a carries over until a new run starts.
    write_reg(REG_BCAST_MODE, {30'd0, BC_HOLD_B});
    feed(5, 100, 1'b0);
    feed(5, 60, 1'b1);
    feed(-20, -5, 1'b0);
    wait_for_results();

    // A scale of one half on a alone puts every odd sample on a tie, under the
    // unused broadcast code, which latches nothing.
    apply_settings(0, 0, 0, 32'h0080_0000, '0, -128, 127, BC_UNUSED);
    feed(1, 77, 1'b1);
    feed(3, -77, 1'b0);
    feed(-1, 0, 1'b1);
    feed(-3, 127, 1'b0);
    feed(5, -128, 1'b0);
    wait_for_results();

    // Largest zero points and multipliers in opposite directions.
    apply_settings(-128, 127, -128, '1, '1, -128, 127, BC_NONE);
    feed(127, -128, 1'b0);
    feed(127, 127, 1'b0);
    feed(-128, -128, 1'b0);
    wait_for_results();

    // Crossed clamp bounds: every sum comes out as clamp_high.
    apply_settings(0, 0, 127, MULT_RESET, MULT_RESET, 10, -10, BC_NONE);
    feed(0, 0, 1'b0);
    feed(100, 0, 1'b0);
    feed(-100, 0, 1'b1);
    wait_for_results();
    directed_pairs = pairs_sent;

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      run_random_phase(phase);
    end

    wait_for_results();
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("Sent %0d directed and %0d random element pairs under %0d register settings.",
             directed_pairs, pairs_sent - directed_pairs, settings_applied);
    $display("Compared %0d sums; %0d random pairs went through a broadcast mode.",
             checked_count, broadcast_pairs);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
